// File: src/sauv_pkg.sv
// shared types, constants and register codes for the sauvola binarizer
package sauv_pkg;

    localparam int HALF_WINDOW_DEF = 6;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int HEIGHT_LIMIT    = 1024;
    localparam int CFG_DW          = 11;
    localparam int CFG_IW          = 3;
    localparam int ROW_W           = 11;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_K_GAIN       = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RANGE_SHIFT  = 3'd3;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;
    localparam logic [7:0]  K_RESET      = 8'd87;
    localparam logic [3:0]  RANGE_RESET  = 4'd8;
    localparam logic [3:0]  RANGE_MAX    = 4'd8;

    typedef struct packed {
        logic [7:0] pixel;
        logic       drain;
    } in_item_t;

    typedef struct packed {
        logic binary;
        logic frame_last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_FLUSH,
        ST_VAR,
        ST_DIFF,
        ST_SQRT,
        ST_THR,
        ST_TSUM,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic idle;
        logic issue;
        logic var_calc;
        logic diff;
        logic sqrt_step;
        logic thr;
        logic tsum;
        logic mul;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic issue_done;
        logic sqrt_done;
        logic out_free;
    } status_t;

endpackage

// File: src/sauvola_local_threshold_binarizer.sv
// top level of the sauvola local threshold binarizer
//
// Gray words come in raster order on the s_ channel (pixel plus a drain flag);
// one binary word per pixel goes out on the m_ channel, frame_last marking the
// last pixel of the frame. Output (r,c) leaves on the input word whose raster
// index is r*W + c + F*W + F (F = HALF_WINDOW), so a frame needs F*W + F drain
// words after its pixels. Words that give no output start no window pass.
// A word that gives an output makes (2F+1)^2 + 1 line store reads
// (one read port, one window pixel a cycle), then variance, bit serial
// square root and threshold math. One word is in flight at a time; the next
// is taken once the result sits in the output register, so a stalled
// receiver blocks only after one result is pending.
// Reset (aresetn low, synchronous) restores the default registers and frame
// position zero; the line store is not cleared and needs no clearing pass.
// Writing image_width or image_height restarts the frame.
module sauvola_local_threshold_binarizer #(
    parameter int HALF_WINDOW = sauv_pkg::HALF_WINDOW_DEF,
    parameter int MAX_WIDTH   = sauv_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [sauv_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sauv_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sauv_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sauv_pkg::out_item_t          m_data
);

    sauv_pkg::cmd_t    cmd;
    sauv_pkg::status_t status;

    sauv_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .status (status),
        .cmd    (cmd)
    );

    sauv_dp #(
        .HALF_WINDOW(HALF_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        status.start |-> cmd.idle)
        else $error("window pass started outside idle");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.idle, cmd.issue, cmd.var_calc, cmd.diff, cmd.sqrt_step,
                  cmd.thr, cmd.tsum, cmd.mul, cmd.finish}))
        else $error("more than one datapath command");

    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        status.sqrt_done |-> cmd.sqrt_step)
        else $error("sqrt done outside sqrt phase");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && status.out_free) |=> m_valid)
        else $error("finished result not presented");

endmodule

// File: src/sauv_ram.sv
// generic simple dual port ram with registered read
module sauv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sauv_ctrl.sv
// controller state machine sequencing window read, variance, sqrt and threshold
module sauv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  sauv_pkg::status_t status,
    output sauv_pkg::cmd_t    cmd
);

    sauv_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sauv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sauv_pkg::ST_IDLE:  if (status.start) state_next = sauv_pkg::ST_SUM;
            sauv_pkg::ST_SUM:   if (status.issue_done) state_next = sauv_pkg::ST_FLUSH;
            sauv_pkg::ST_FLUSH: state_next = sauv_pkg::ST_VAR;
            sauv_pkg::ST_VAR:   state_next = sauv_pkg::ST_DIFF;
            sauv_pkg::ST_DIFF:  state_next = sauv_pkg::ST_SQRT;
            sauv_pkg::ST_SQRT:  if (status.sqrt_done) state_next = sauv_pkg::ST_THR;
            sauv_pkg::ST_THR:   state_next = sauv_pkg::ST_TSUM;
            sauv_pkg::ST_TSUM:  state_next = sauv_pkg::ST_MUL;
            sauv_pkg::ST_MUL:   state_next = sauv_pkg::ST_OUT;
            sauv_pkg::ST_OUT:   if (status.out_free) state_next = sauv_pkg::ST_IDLE;
            default:            state_next = sauv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            sauv_pkg::ST_IDLE: cmd.idle      = 1'b1;
            sauv_pkg::ST_SUM:  cmd.issue     = 1'b1;
            sauv_pkg::ST_VAR:  cmd.var_calc  = 1'b1;
            sauv_pkg::ST_DIFF: cmd.diff      = 1'b1;
            sauv_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
            sauv_pkg::ST_THR:  cmd.thr       = 1'b1;
            sauv_pkg::ST_TSUM: cmd.tsum      = 1'b1;
            sauv_pkg::ST_MUL:  cmd.mul       = 1'b1;
            sauv_pkg::ST_OUT:  cmd.finish    = 1'b1;
            default:           cmd           = '0;
        endcase
    end

endmodule

// File: src/sauv_dp.sv
// datapath: config, raster positions, line store, window sums, sqrt and threshold test
module sauv_dp #(
    parameter int HALF_WINDOW = sauv_pkg::HALF_WINDOW_DEF,
    parameter int MAX_WIDTH   = sauv_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sauv_pkg::cmd_t               cmd,
    output sauv_pkg::status_t            status,
    input  logic                         cfg_we,
    input  logic [sauv_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [sauv_pkg::CFG_DW-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sauv_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sauv_pkg::out_item_t          m_data
);

    localparam int SIDE    = 2 * HALF_WINDOW + 1;
    localparam int WIN_N   = SIDE * SIDE;
    localparam int RING    = SIDE + 1;
    localparam int NW      = $clog2(WIN_N + 1);
    localparam int SW      = $clog2(WIN_N * 255 + 1);
    localparam int QW      = $clog2(WIN_N * 65025 + 1);
    localparam int DW      = 2 * SW;
    localparam int N2W     = $clog2(WIN_N * WIN_N + 1);
    localparam int OW      = $clog2(SIDE);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int RGW     = $clog2(RING);
    localparam int AW      = $clog2(RING * MAX_WIDTH);
    localparam int LGW     = $clog2(HALF_WINDOW * MAX_WIDTH + HALF_WINDOW + 1);
    localparam int BW      = 9 + NW + 8;
    localparam int KW      = 8 + SW;
    localparam int TW      = ((BW > KW) ? BW : KW) + 1;
    localparam int LW      = 8 + N2W + 16;
    localparam int PW      = SW + TW;
    localparam int CMPW    = (PW > LW) ? PW : LW;
    localparam int SQW     = $clog2(SW);
    localparam int HW      = sauv_pkg::ROW_W;

    localparam logic signed [HW+1:0]  F_S    = (HW + 2)'(HALF_WINDOW);
    localparam logic signed [RGW+1:0] RING_S = (RGW + 2)'(RING);

    // configuration
    logic [10:0] img_w_reg, img_h_reg;
    logic [7:0]  k_reg;
    logic [3:0]  rs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= sauv_pkg::WIDTH_RESET;
            img_h_reg <= sauv_pkg::HEIGHT_RESET;
            k_reg     <= sauv_pkg::K_RESET;
            rs_reg    <= sauv_pkg::RANGE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                sauv_pkg::REG_IMAGE_WIDTH:  img_w_reg <= cfg_wdata;
                sauv_pkg::REG_IMAGE_HEIGHT: img_h_reg <= cfg_wdata;
                sauv_pkg::REG_K_GAIN:       k_reg     <= cfg_wdata[7:0];
                sauv_pkg::REG_RANGE_SHIFT:  rs_reg    <= cfg_wdata[3:0];
                default:                    ;
            endcase
        end
    end

    logic          geom_write;
    logic [WW-1:0] eff_w;
    logic [CW-1:0] w_m1;
    logic [HW-1:0] eff_h, h_m1;
    logic [3:0]    rs_eff;
    logic [LGW-1:0] lag;

    assign geom_write = cfg_we && (cfg_index == sauv_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == sauv_pkg::REG_IMAGE_HEIGHT);

    always_comb begin
        if (img_w_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(img_w_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(img_w_reg);
        end
        if (img_h_reg == '0) begin
            eff_h = HW'(1);
        end else if (32'(img_h_reg) > 32'(sauv_pkg::HEIGHT_LIMIT)) begin
            eff_h = HW'(sauv_pkg::HEIGHT_LIMIT);
        end else begin
            eff_h = img_h_reg;
        end
    end

    assign w_m1   = CW'(eff_w - WW'(1));
    assign h_m1   = eff_h - HW'(1);
    assign rs_eff = (rs_reg > sauv_pkg::RANGE_MAX) ? sauv_pkg::RANGE_MAX : rs_reg;
    assign lag    = LGW'(HALF_WINDOW) * LGW'(eff_w) + LGW'(HALF_WINDOW);

    // input side
    logic [CW-1:0]  in_col_reg;
    logic [HW-1:0]  in_row_reg;
    logic [RGW-1:0] in_ring_reg;
    logic [LGW-1:0] lag_cnt_reg;
    logic           accept, in_frame, take, emit;

    assign s_ready  = cmd.idle;
    assign accept   = s_valid && s_ready;
    assign in_frame = in_row_reg < eff_h;
    assign take     = accept && !(in_frame && s_data.drain);
    assign emit     = lag_cnt_reg == lag;

    // output side
    logic [CW-1:0]  out_col_reg;
    logic [HW-1:0]  out_row_reg;
    logic [RGW-1:0] out_ring_reg;
    logic           out_free, frame_end, last_pix;
    logic           m_valid_reg;
    sauv_pkg::out_item_t m_data_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_pix  = (out_row_reg == h_m1) && (out_col_reg == w_m1);
    assign frame_end = cmd.finish && out_free && last_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            lag_cnt_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
        end else if (geom_write || frame_end) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            lag_cnt_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
        end else begin
            if (take) begin
                if (in_col_reg == w_m1) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + HW'(1);
                    in_ring_reg <= (in_ring_reg == RGW'(RING - 1)) ? '0
                                                                   : in_ring_reg + RGW'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
                if (!emit) begin
                    lag_cnt_reg <= lag_cnt_reg + LGW'(1);
                end
            end
            if (cmd.finish && out_free) begin
                if (out_col_reg == w_m1) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + HW'(1);
                    out_ring_reg <= (out_ring_reg == RGW'(RING - 1)) ? '0
                                                                     : out_ring_reg + RGW'(1);
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // window address generation
    logic [OW-1:0] dy_reg, dx_reg;
    logic          center_reg;
    logic signed [HW+1:0]  rr_s, roff;
    logic signed [CW+1:0]  cc_s;
    logic signed [RGW+1:0] ring_s;
    logic [HW-1:0]  rr;
    logic [CW-1:0]  cc;
    logic [RGW-1:0] ring;
    logic [AW-1:0]  raddr, waddr;
    logic [7:0]     rdata;

    always_comb begin
        rr_s = $signed({2'b00, out_row_reg}) + $signed((HW + 2)'(dy_reg)) - F_S;
        if (rr_s < 0) begin
            rr = '0;
        end else if (rr_s > $signed({2'b00, h_m1})) begin
            rr = h_m1;
        end else begin
            rr = rr_s[HW-1:0];
        end
        roff   = $signed({2'b00, rr}) - $signed({2'b00, out_row_reg});
        ring_s = $signed({2'b00, out_ring_reg}) + roff[RGW+1:0];
        if (ring_s < 0) begin
            ring_s = ring_s + RING_S;
        end else if (ring_s >= RING_S) begin
            ring_s = ring_s - RING_S;
        end
        ring = ring_s[RGW-1:0];
        cc_s = $signed({2'b00, out_col_reg}) + $signed((CW + 2)'(dx_reg))
             - $signed((CW + 2)'(HALF_WINDOW));
        if (cc_s < 0) begin
            cc = '0;
        end else if (cc_s > $signed({2'b00, w_m1})) begin
            cc = w_m1;
        end else begin
            cc = cc_s[CW-1:0];
        end
        if (center_reg) begin
            raddr = AW'(out_ring_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg);
        end else begin
            raddr = AW'(ring) * AW'(MAX_WIDTH) + AW'(cc);
        end
    end

    assign waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    sauv_ram #(
        .WIDTH(8),
        .DEPTH(RING * MAX_WIDTH)
    ) u_line_store (
        .aclk (aclk),
        .we   (take && in_frame),
        .waddr(waddr),
        .wdata(s_data.pixel),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dy_reg     <= '0;
            dx_reg     <= '0;
            center_reg <= 1'b0;
        end else if (cmd.idle) begin
            dy_reg     <= '0;
            dx_reg     <= '0;
            center_reg <= 1'b0;
        end else if (cmd.issue && !center_reg) begin
            if (dx_reg == OW'(SIDE - 1)) begin
                dx_reg <= '0;
                if (dy_reg == OW'(SIDE - 1)) begin
                    center_reg <= 1'b1;
                end else begin
                    dy_reg <= dy_reg + OW'(1);
                end
            end else begin
                dx_reg <= dx_reg + OW'(1);
            end
        end
    end

    // accumulation, one word per cycle behind the read
    logic          rd_valid_reg, rd_center_reg;
    logic [SW-1:0] s_reg;
    logic [QW-1:0] q_reg;
    logic [7:0]    p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            rd_center_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.issue;
            rd_center_reg <= cmd.issue && center_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idle) begin
            s_reg <= '0;
            q_reg <= '0;
        end else if (rd_valid_reg && !rd_center_reg) begin
            s_reg <= s_reg + SW'(rdata);
            q_reg <= q_reg + QW'(16'(rdata) * 16'(rdata));
        end
        if (rd_center_reg) begin
            p_reg <= rdata;
        end
    end

    // variance and integer square root, one root bit per cycle
    logic [DW-1:0]  nq_reg, ss_reg, rem_reg, root_reg, bit_reg, trial;
    logic [SQW-1:0] sq_cnt_reg;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.var_calc) begin
            nq_reg <= DW'(q_reg) * DW'(WIN_N);
            ss_reg <= DW'(s_reg) * DW'(s_reg);
        end
        if (cmd.diff) begin
            rem_reg  <= nq_reg - ss_reg;
            root_reg <= '0;
            bit_reg  <= DW'(1) << (DW - 2);
        end else if (cmd.sqrt_step) begin
            if (rem_reg >= trial) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (cmd.diff) begin
            sq_cnt_reg <= '0;
        end else if (cmd.sqrt_step) begin
            sq_cnt_reg <= sq_cnt_reg + SQW'(1);
        end
    end

    // threshold test: p*256*N^2*R <= S*((256-k)*N*R + k*dev)
    logic [KW-1:0]      kdev_reg;
    logic [BW-1:0]      base_reg;
    logic [N2W+7:0]     lbase_reg;
    logic [TW-1:0]      tsum_reg;
    logic [CMPW-1:0]    lhs_reg, rhs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.thr) begin
            kdev_reg  <= KW'(k_reg) * KW'(root_reg[SW-1:0]);
            base_reg  <= (BW'(9'(9'd256 - 9'(k_reg))) * BW'(WIN_N)) << rs_eff;
            lbase_reg <= (N2W + 8)'(p_reg) * (N2W + 8)'(WIN_N * WIN_N);
        end
        if (cmd.tsum) begin
            tsum_reg <= TW'(base_reg) + TW'(kdev_reg);
            lhs_reg  <= CMPW'(lbase_reg) << (5'd8 + 5'(rs_eff));
        end
        if (cmd.mul) begin
            rhs_reg <= CMPW'(s_reg) * CMPW'(tsum_reg);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && out_free) begin
            m_data_reg.binary     <= lhs_reg > rhs_reg;
            m_data_reg.frame_last <= last_pix;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.start      = take && emit;
    assign status.issue_done = cmd.issue && center_reg;
    assign status.sqrt_done  = cmd.sqrt_step && (sq_cnt_reg == SQW'(SW - 1));
    assign status.out_free   = out_free;

endmodule

// File: dv/testbench.sv
// testbench for the sauvola local threshold binarizer: random frames checked against a predictor
module testbench;

    localparam int HW       = sauv_pkg::HALF_WINDOW_DEF;
    localparam int MAXW     = sauv_pkg::MAX_WIDTH_DEF;
    localparam int RING     = 2 * HW + 2;
    localparam int SIDE     = 2 * HW + 1;
    localparam longint unsigned NWIN = SIDE * SIDE;
    localparam int QUIET_LIMIT = 20000;
    localparam int ITEM_TARGET = 600;
    // index past the register set, written to check it changes nothing
    localparam logic [sauv_pkg::CFG_IW-1:0] REG_NONE = 3'd5;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [sauv_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [sauv_pkg::CFG_DW-1:0] cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    sauv_pkg::in_item_t          s_data = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    sauv_pkg::out_item_t         m_data;

    sauvola_local_threshold_binarizer u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    logic [7:0]  gray_ring [0:RING*MAXW-1];
    int unsigned row_pos, col_pos;
    logic [10:0] reg_width, reg_height;
    logic [7:0]  reg_k;
    logic [3:0]  reg_range;

    sauv_pkg::in_item_t  pixel_q[$];
    sauv_pkg::out_item_t binary_q[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          hold_request = 0;
    bit          hold_taken = 0;
    int          hold_left = 0;
    int unsigned cyc = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic threshold_bit(int r, int c, int w, int h);
        longint unsigned s, q, v, d, dev, kk, p, lhs, rhs;
        int rr, cc, rs;
        s = 0;
        q = 0;
        for (int dy = -HW; dy <= HW; dy++) begin
            rr = clip(r + dy, 0, h - 1);
            for (int dx = -HW; dx <= HW; dx++) begin
                cc = clip(c + dx, 0, w - 1);
                v = 64'(gray_ring[(rr % RING) * MAXW + cc]);
                s += v;
                q += v * v;
            end
        end
        d = NWIN * q - s * s;
        dev = int_sqrt(d);
        rs = (reg_range > sauv_pkg::RANGE_MAX) ? int'(sauv_pkg::RANGE_MAX) : int'(reg_range);
        kk = 64'(reg_k);
        p = 64'(gray_ring[(r % RING) * MAXW + c]);
        lhs = (p * 256 * NWIN * NWIN) << rs;
        rhs = s * ((((256 - kk) * NWIN) << rs) + kk * dev);
        return (lhs <= rhs) ? 1'b0 : 1'b1;
    endfunction

    task automatic predict_word(sauv_pkg::in_item_t it);
        int unsigned w, h, ri, ci, r, c;
        longint unsigned n, lag, m;
        sauv_pkg::out_item_t o;
        w = (reg_width < 1) ? 1 : ((reg_width > MAXW) ? MAXW : 32'(reg_width));
        h = (reg_height < 1) ? 1 : ((reg_height > sauv_pkg::HEIGHT_LIMIT)
                                    ? sauv_pkg::HEIGHT_LIMIT : 32'(reg_height));
        ri = row_pos;
        ci = col_pos;
        if (ci >= w) ci = w - 1;
        if (ri < h) begin
            // drain inside the frame is dropped
            if (it.drain) return;
            gray_ring[(ri % RING) * MAXW + ci] = it.pixel;
        end
        n = longint'(ri) * w + ci;
        lag = HW * w + HW;
        ci++;
        if (ci >= w) begin
            ci = 0;
            ri++;
        end
        row_pos = ri;
        col_pos = ci;
        if (n < lag) return;
        m = n - lag;
        r = 32'(m / w);
        c = 32'(m % w);
        if (r >= h) r = h - 1;
        o.binary = threshold_bit(r, c, w, h);
        o.frame_last = (r == h - 1 && c == w - 1);
        if (o.frame_last) begin
            row_pos = 0;
            col_pos = 0;
        end
        binary_q.push_back(o);
    endtask

    task automatic write_reg(logic [sauv_pkg::CFG_IW-1:0] idx,
                             logic [sauv_pkg::CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            sauv_pkg::REG_IMAGE_WIDTH: begin
                reg_width = val;
                row_pos = 0;
                col_pos = 0;
            end
            sauv_pkg::REG_IMAGE_HEIGHT: begin
                reg_height = val;
                row_pos = 0;
                col_pos = 0;
            end
            sauv_pkg::REG_K_GAIN: reg_k = val[7:0];
            sauv_pkg::REG_RANGE_SHIFT: reg_range = val[3:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_gray();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // one frame of pixels (with stray drain words when noisy) then the drain words that push it out
    task automatic queue_frame(int w, int h, bit noisy);
        sauv_pkg::in_item_t it;
        for (int i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                it.pixel = 8'($urandom);
                it.drain = 1'b1;
                pixel_q.push_back(it);
            end
            it.pixel = pick_gray();
            it.drain = 1'b0;
            pixel_q.push_back(it);
        end
        for (int i = 0; i < HW * w + HW; i++) begin
            it.pixel = 8'($urandom);
            // a pixel past the frame end acts as a drain
            it.drain = (noisy && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
            pixel_q.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_valid || binary_q.size() > 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    task automatic run_frame(int w, int h, int k, int rs, bit noisy);
        write_reg(sauv_pkg::REG_IMAGE_WIDTH, sauv_pkg::CFG_DW'(w));
        write_reg(sauv_pkg::REG_IMAGE_HEIGHT, sauv_pkg::CFG_DW'(h));
        write_reg(sauv_pkg::REG_K_GAIN, sauv_pkg::CFG_DW'(k));
        write_reg(sauv_pkg::REG_RANGE_SHIFT, sauv_pkg::CFG_DW'(rs));
        queue_frame(w, h, noisy);
        wait_drained();
    endtask

    function automatic int frame_items(int w, int h);
        return w * h + HW * w + HW;
    endfunction

    // sender: bursts with gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                s_data <= pixel_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 250);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, free stretches, one long hold
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (cyc[12]) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_word(s_data);
    end

    always @(posedge aclk) begin
        sauv_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (binary_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: binary=%0b frame_last=%0b",
                             m_data.binary, m_data.frame_last);
            end else begin
                want = binary_q.pop_front();
                if (m_data.binary !== want.binary || m_data.frame_last !== want.frame_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected binary=%0b last=%0b got binary=%0b last=%0b",
                                 want.binary, want.frame_last, m_data.binary, m_data.frame_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int items_sent;
        int w, h;
        for (int i = 0; i < RING * MAXW; i++) gray_ring[i] = 8'd0;
        row_pos = 0;
        col_pos = 0;
        reg_width = sauv_pkg::WIDTH_RESET;
        reg_height = sauv_pkg::HEIGHT_RESET;
        reg_k = sauv_pkg::K_RESET;
        reg_range = sauv_pkg::RANGE_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        items_sent = 0;

        // directed corners
        run_frame(1, 1, 0, 0, 0);
        items_sent += frame_items(1, 1);
        run_frame(1, 1, 255, 15, 0);
        items_sent += frame_items(1, 1);
        write_reg(REG_NONE, 11'h7ff);
        run_frame(2, 2, 255, 8, 1);
        items_sent += frame_items(2, 2);
        run_frame(3, 1, 87, 0, 1);
        items_sent += frame_items(3, 1);

        // tall single column
        run_frame(1, 40, $urandom_range(0, 255), $urandom_range(0, 15), 1);
        items_sent += frame_items(1, 40);

        while (items_sent < ITEM_TARGET) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            if (items_sent > 200) hold_request = 1;
            run_frame(w, h, $urandom_range(0, 255), $urandom_range(0, 15),
                      $urandom_range(0, 2) != 0);
            items_sent += frame_items(w, h);
        end

        if (mismatches == 0 && binary_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
